// ----- design/gqdp_pkg.sv -----
// ----------------------------------------------------------------------------
// gqdp_pkg: shared types and constants of the group quantized dot product
// Field widths, quantization mode codes, fp16 scale constants and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gqdp_pkg;

  // Input item fields.
  localparam int CODE_W  = 8;
  localparam int HIGH_W  = 8;
  localparam int LANE_W  = 5;
  localparam int SCALE_W = 16;
  localparam int ACT_W   = 24;
  localparam int IN_W    = CODE_W + HIGH_W + LANE_W + SCALE_W + 2 * ACT_W;
  localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;

  // Result item fields.
  localparam int SUM_W   = 48;
  localparam int OUT_BYTES_W = ((SUM_W + 7) / 8) * 8;

  // Internal widths.
  localparam int PROD_W  = CODE_W + ACT_W;
  localparam int GROUP_W = 40;
  localparam int GSUM_W  = GROUP_W + 2;
  localparam int RSUM_W  = SUM_W + 1;
  localparam int SIG_W   = 11;
  localparam int SPROD_W = GROUP_W + SIG_W + 1;
  localparam int MAX_LSH = 5;
  localparam int SHIFT_W = SPROD_W - 1 + MAX_LSH;
  localparam int CONTRIB_W = SHIFT_W + 1;

  localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(31);

  // fp16 scale decoding.
  localparam logic [4:0] EXP_INF      = 5'h1f;
  localparam logic [4:0] EXP_SUBNORM  = 5'h00;
  localparam logic [4:0] EXP_BIAS     = 5'd25;
  localparam logic [4:0] SUBNORM_RSH  = 5'd24;

  localparam logic signed [GROUP_W-1:0] GROUP_MAX = {1'b0, {(GROUP_W-1){1'b1}}};
  localparam logic signed [GROUP_W-1:0] GROUP_MIN = {1'b1, {(GROUP_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

  // Quantization modes.
  localparam logic [1:0] MODE_Q4 = 2'd0;
  localparam logic [1:0] MODE_Q5 = 2'd1;
  localparam logic [1:0] MODE_Q6 = 2'd2;
  localparam logic [1:0] MODE_Q8 = 2'd3;

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic scale;
    logic shift;
    logic add;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic close_group;
    logic last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- design/group_quantized_dot_product.sv -----
// ----------------------------------------------------------------------------
// group_quantized_dot_product: quantized weight row times activations
// Unpacks 4, 5, 6 or 8 bit weight codes, sums lane products per group,
// scales each group sum by its fp16 scale and accumulates a saturating
// Q32.16 row sum that is sent out on the row's last lane.
//
//   Channel   Direction  Contents
//   s_axis    in         one lane of the weight row with its activations
//   m_axis    out        row dot product and overflow flag
//   cfg       in         quant_mode register write
//
// A lane that does not close a group is captured, multiplied and
// accumulated. A group-closing lane then also goes through the scale
// multiply, the exponent shift with rounding and the row add. A row's last
// lane then loads the output register; it waits there while an earlier
// result is still held. Reset clears the group and row sums and the
// overflow flag and sets quant_mode to four-bit mode.
// ----------------------------------------------------------------------------
`default_nettype none

module group_quantized_dot_product (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [1:0]                         cfg_wdata,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // code_byte, hi_bits, lane, scale_word, x_even, x_odd, zero pad
  input  wire logic [gqdp_pkg::IN_BYTES_W-1:0]    s_axis_tdata,
  input  wire logic                               s_axis_tlast,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // dot_sum
  output logic [gqdp_pkg::OUT_BYTES_W-1:0]        m_axis_tdata,
  // overflow
  output logic                                    m_axis_tuser
);

  gqdp_pkg::cmd_t    cmd;
  gqdp_pkg::status_t status;
  logic [gqdp_pkg::SUM_W-1:0] out_sum;

  gqdp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gqdp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_sum   (out_sum),
    .out_ovf   (m_axis_tuser)
  );

  assign m_axis_tdata = gqdp_pkg::OUT_BYTES_W'(out_sum);

endmodule

`default_nettype wire

// ----- design/gqdp_ctrl.sv -----
// ----------------------------------------------------------------------------
// gqdp_ctrl: sequencing controller
// Steps an item through multiply and group accumulate; a group-closing item
// also through scale, round and row add; a row's last loads the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gqdp_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire gqdp_pkg::status_t status,
  output gqdp_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_SCALE,
    ST_SHIFT,
    ST_ADD,
    ST_EMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE:  if (in_valid) state <= ST_MUL;
        ST_MUL:   state <= ST_ACC;
        ST_ACC:   state <= status.close_group ? ST_SCALE : ST_IDLE;
        ST_SCALE: state <= ST_SHIFT;
        ST_SHIFT: state <= ST_ADD;
        ST_ADD:   state <= status.last ? ST_EMIT : ST_IDLE;
        ST_EMIT:  if (status.out_free) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.load  = (state == ST_IDLE) && in_valid;
    cmd.mul   = (state == ST_MUL);
    cmd.acc   = (state == ST_ACC);
    cmd.scale = (state == ST_SCALE);
    cmd.shift = (state == ST_SHIFT);
    cmd.add   = (state == ST_ADD);
    cmd.emit  = (state == ST_EMIT) && status.out_free;
  end

  a_group_close_scales: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC && status.close_group) |=> (state == ST_SCALE))
    else $error("closing lane did not start scaling");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD && status.last) |=> (state == ST_EMIT))
    else $error("last lane did not lead to a result");

  a_emit_waits_output: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !status.out_free) |=> (state == ST_EMIT))
    else $error("left emit while output register was full");

endmodule

`default_nettype wire

// ----- design/gqdp_datapath.sv -----
// ----------------------------------------------------------------------------
// gqdp_datapath: code unpacking, multipliers, accumulators and scaling
// Holds the input item, lane products, the 40 bit group sum, the fp16
// scaling path with round-half-away rounding, the saturating row sum and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gqdp_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [1:0]                         cfg_wdata,
  input  wire logic [gqdp_pkg::IN_BYTES_W-1:0]    in_data,
  input  wire logic                               in_last,
  input  wire gqdp_pkg::cmd_t                     cmd,
  output gqdp_pkg::status_t                       status,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [gqdp_pkg::SUM_W-1:0]              out_sum,
  output logic                                    out_ovf
);

  logic [1:0] quant_mode;

  // Captured input item.
  logic [gqdp_pkg::CODE_W-1:0]         code_q;
  logic [gqdp_pkg::HIGH_W-1:0]         high_q;
  logic [gqdp_pkg::LANE_W-1:0]         lane_q;
  logic [gqdp_pkg::SCALE_W-1:0]        scale_q;
  logic signed [gqdp_pkg::ACT_W-1:0]   xe_q;
  logic signed [gqdp_pkg::ACT_W-1:0]   xo_q;
  logic                                last_q;

  logic signed [gqdp_pkg::PROD_W-1:0]    p0;
  logic signed [gqdp_pkg::PROD_W-1:0]    p1;
  logic signed [gqdp_pkg::GROUP_W-1:0]   group_sum;
  logic signed [gqdp_pkg::SPROD_W-1:0]   sprod;
  logic signed [gqdp_pkg::CONTRIB_W-1:0] contrib;
  logic                                  scale_inf;
  logic signed [gqdp_pkg::SUM_W-1:0]     row_sum;
  logic                                  ovf_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      quant_mode <= gqdp_pkg::MODE_Q4;
    end else if (cfg_we) begin
      quant_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_q  <= in_data[7:0];
      high_q  <= in_data[15:8];
      lane_q  <= in_data[20:16];
      scale_q <= in_data[36:21];
      xe_q    <= $signed(in_data[60:37]);
      xo_q    <= $signed(in_data[84:61]);
      last_q  <= in_last;
    end
  end

  // Code unpacking.
  logic [3:0]        q0;
  logic [3:0]        q1;
  logic [1:0]        h5;
  logic [3:0]        h6;
  logic signed [7:0] c0;
  logic signed [7:0] c1;

  always_comb begin
    q0 = code_q[3:0];
    q1 = code_q[7:4];
    h5 = 2'(high_q >> {lane_q[1:0], 1'b0});
    h6 = lane_q[0] ? high_q[7:4] : high_q[3:0];
    case (quant_mode)
      gqdp_pkg::MODE_Q4: begin
        c0 = {{4{q0[3]}}, q0};
        c1 = {{4{q1[3]}}, q1};
      end
      gqdp_pkg::MODE_Q5: begin
        c0 = {{4{h5[0]}}, q0};
        c1 = {{4{h5[1]}}, q1};
      end
      gqdp_pkg::MODE_Q6: begin
        c0 = {{2{h6[1]}}, h6[1:0], q0};
        c1 = {{2{h6[3]}}, h6[3:2], q1};
      end
      default: begin
        c0 = $signed(code_q);
        c1 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p0 <= c0 * xe_q;
      p1 <= c1 * xo_q;
    end
  end

  // Group accumulation with saturation.
  logic signed [gqdp_pkg::GSUM_W-1:0]  gsum_wide;
  logic signed [gqdp_pkg::GROUP_W-1:0] gsum_sat;
  logic                                gsum_ovf;

  always_comb begin
    gsum_wide = gqdp_pkg::GSUM_W'(group_sum) + gqdp_pkg::GSUM_W'(p0)
              + gqdp_pkg::GSUM_W'(p1);
    gsum_ovf  = 1'b1;
    if (gsum_wide > gqdp_pkg::GSUM_W'(gqdp_pkg::GROUP_MAX)) begin
      gsum_sat = gqdp_pkg::GROUP_MAX;
    end else if (gsum_wide < gqdp_pkg::GSUM_W'(gqdp_pkg::GROUP_MIN)) begin
      gsum_sat = gqdp_pkg::GROUP_MIN;
    end else begin
      gsum_sat = gsum_wide[gqdp_pkg::GROUP_W-1:0];
      gsum_ovf = 1'b0;
    end
  end

  // fp16 scale decode.
  logic [4:0]                 sc_exp;
  logic [gqdp_pkg::SIG_W-1:0] sc_sig;

  assign sc_exp = scale_q[14:10];
  assign sc_sig = {(sc_exp != gqdp_pkg::EXP_SUBNORM), scale_q[9:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      group_sum <= '0;
    end else if (cmd.acc) begin
      group_sum <= gsum_sat;
    end else if (cmd.scale || cmd.emit) begin
      group_sum <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      sprod <= group_sum * $signed({1'b0, sc_sig});
    end
  end

  // Exponent shift with round half away from zero on the magnitude.
  logic [gqdp_pkg::SPROD_W-1:0]     sprod_neg;
  logic [gqdp_pkg::SPROD_W-2:0]     mag;
  logic [4:0]                       rsh;
  logic [2:0]                       lsh;
  logic [gqdp_pkg::SHIFT_W-1:0]     mag_l;
  logic [gqdp_pkg::SHIFT_W-1:0]     rnd;
  logic [gqdp_pkg::SHIFT_W-1:0]     shifted;
  logic                             negate;
  logic signed [gqdp_pkg::CONTRIB_W-1:0] contrib_next;

  always_comb begin
    sprod_neg = -sprod;
    mag = sprod[gqdp_pkg::SPROD_W-1] ? sprod_neg[gqdp_pkg::SPROD_W-2:0]
                                     : sprod[gqdp_pkg::SPROD_W-2:0];
    rsh = '0;
    lsh = '0;
    if (sc_exp == gqdp_pkg::EXP_SUBNORM) begin
      rsh = gqdp_pkg::SUBNORM_RSH;
    end else if (sc_exp > gqdp_pkg::EXP_BIAS) begin
      lsh = 3'(sc_exp - gqdp_pkg::EXP_BIAS);
    end else begin
      rsh = gqdp_pkg::EXP_BIAS - sc_exp;
    end
    mag_l   = gqdp_pkg::SHIFT_W'(mag) << lsh;
    rnd     = (rsh == 5'd0) ? '0 : (gqdp_pkg::SHIFT_W'(1) << (rsh - 5'd1));
    shifted = (mag_l + rnd) >> rsh;
    negate  = sprod[gqdp_pkg::SPROD_W-1] ^ scale_q[15];
    if (sc_exp == gqdp_pkg::EXP_INF) begin
      contrib_next = '0;
    end else if (negate) begin
      contrib_next = -$signed({1'b0, shifted});
    end else begin
      contrib_next = $signed({1'b0, shifted});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      contrib   <= contrib_next;
      scale_inf <= (sc_exp == gqdp_pkg::EXP_INF);
    end
  end

  // Clamp the group contribution, then the saturating row add.
  logic signed [gqdp_pkg::SUM_W-1:0]  c_sat;
  logic                               c_ovf;
  logic signed [gqdp_pkg::RSUM_W-1:0] rsum_wide;
  logic signed [gqdp_pkg::SUM_W-1:0]  rsum_sat;
  logic                               rsum_ovf;

  always_comb begin
    c_ovf = 1'b1;
    if (contrib > gqdp_pkg::CONTRIB_W'(gqdp_pkg::SUM_MAX)) begin
      c_sat = gqdp_pkg::SUM_MAX;
    end else if (contrib < gqdp_pkg::CONTRIB_W'(gqdp_pkg::SUM_MIN)) begin
      c_sat = gqdp_pkg::SUM_MIN;
    end else begin
      c_sat = contrib[gqdp_pkg::SUM_W-1:0];
      c_ovf = 1'b0;
    end
    rsum_wide = gqdp_pkg::RSUM_W'(row_sum) + gqdp_pkg::RSUM_W'(c_sat);
    rsum_ovf  = 1'b1;
    if (rsum_wide > gqdp_pkg::RSUM_W'(gqdp_pkg::SUM_MAX)) begin
      rsum_sat = gqdp_pkg::SUM_MAX;
    end else if (rsum_wide < gqdp_pkg::RSUM_W'(gqdp_pkg::SUM_MIN)) begin
      rsum_sat = gqdp_pkg::SUM_MIN;
    end else begin
      rsum_sat = rsum_wide[gqdp_pkg::SUM_W-1:0];
      rsum_ovf = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum  <= '0;
      ovf_seen <= 1'b0;
    end else if (cmd.emit) begin
      row_sum  <= '0;
      ovf_seen <= 1'b0;
    end else if (cmd.acc) begin
      ovf_seen <= ovf_seen | gsum_ovf;
    end else if (cmd.add) begin
      row_sum  <= rsum_sat;
      ovf_seen <= ovf_seen | c_ovf | rsum_ovf | scale_inf;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sum <= row_sum;
      out_ovf <= ovf_seen;
    end
  end

  always_comb begin
    status.close_group = (lane_q == gqdp_pkg::LAST_LANE) || last_q;
    status.last        = last_q;
    status.out_free    = !out_valid || out_ready;
  end

  a_scale_clears_group: assert property (@(posedge clk) disable iff (rst)
    cmd.scale |=> (group_sum == '0))
    else $error("group sum not cleared after scaling");

  a_emit_clears_row: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (row_sum == '0 && !ovf_seen && out_valid))
    else $error("row state not cleared after result");

  a_inf_scale_flags: assert property (@(posedge clk) disable iff (rst)
    (cmd.add && scale_inf) |=> ovf_seen)
    else $error("infinite or NaN scale did not raise overflow");

endmodule

`default_nettype wire
